/* rtl/qte_pkg.sv */
// Shared types, constants and the arctangent table of the quaternion to Euler angle core.
package qte_pkg;

	localparam int TERM_W     = 35;
	localparam int CORDIC_W   = 37;
	localparam int ISQRT_BITS = 31;
	localparam int ISQRT_IN_W = 2 * ISQRT_BITS;
	localparam int ISQRT_REM_W = ISQRT_BITS + 4;
	localparam int MAG_W      = 30;
	localparam int ATAN_LEN   = 24;
	localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(64'sd1 <<< 30);

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic               pitch_clamped;
	} angles_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] sr;
		logic signed [TERM_W-1:0] cr;
		logic signed [TERM_W-1:0] sp;
		logic signed [TERM_W-1:0] sy;
		logic signed [TERM_W-1:0] cy;
	} terms_t;

	typedef struct packed {
		logic clamped;
		logic negative;
	} clamp_t;

	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/qte_terms.sv */
// Two-stage product and sum pipeline that forms the five ZYX conversion terms.
module qte_terms (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  qte_pkg::quat_t  quat,
	output logic            out_valid,
	output qte_pkg::terms_t terms
);

	logic               vld_s1;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, xz_s1, wz_s1, xy_s1, zz_s1;
	logic               vld_s2;
	qte_pkg::terms_t    terms_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= quat.quat_w * quat.quat_x;
		yz_s1 <= quat.quat_y * quat.quat_z;
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		wy_s1 <= quat.quat_w * quat.quat_y;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xy_s1 <= quat.quat_x * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		terms_s2.sr <= (qte_pkg::TERM_W'(wx_s1) + qte_pkg::TERM_W'(yz_s1)) <<< 1;
		terms_s2.cr <= qte_pkg::ONE_Q30
			- ((qte_pkg::TERM_W'(xx_s1) + qte_pkg::TERM_W'(yy_s1)) <<< 1);
		terms_s2.sp <= (qte_pkg::TERM_W'(wy_s1) - qte_pkg::TERM_W'(xz_s1)) <<< 1;
		terms_s2.sy <= (qte_pkg::TERM_W'(wz_s1) + qte_pkg::TERM_W'(xy_s1)) <<< 1;
		terms_s2.cy <= qte_pkg::ONE_Q30
			- ((qte_pkg::TERM_W'(yy_s1) + qte_pkg::TERM_W'(zz_s1)) <<< 1);
	end

	assign out_valid = vld_s2;
	assign terms     = terms_s2;

endmodule

/* rtl/qte_isqrt.sv */
// Pipelined floor integer square root, one result bit per stage.
module qte_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [qte_pkg::ISQRT_IN_W-1:0]     radicand,
	output logic                               out_valid,
	output logic [qte_pkg::ISQRT_BITS-1:0]     root
);

	localparam int N  = qte_pkg::ISQRT_BITS;
	localparam int RW = qte_pkg::ISQRT_REM_W;
	localparam int VW = qte_pkg::ISQRT_IN_W;

	logic          vld_s [0:N];
	logic [RW-1:0] rem_s [0:N];
	logic [N-1:0]  root_s [0:N];
	logic [VW-1:0] rad_s [0:N];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] trial;
		logic [RW-1:0] sub;
		logic          fits;

		assign trial = {rem_s[k][RW-3:0], rad_s[k][VW-1 -: 2]};
		assign sub   = RW'({root_s[k], 2'b01});
		assign fits  = trial >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= fits ? trial - sub : trial;
			root_s[k+1] <= {root_s[k][N-2:0], fits};
			rad_s[k+1]  <= rad_s[k] << 2;
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];

endmodule

/* rtl/qte_cordic.sv */
// Pipelined CORDIC vectoring unit that returns atan2(y, x) as a binary angle.
module qte_cordic #(
	parameter int STEPS      = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [qte_pkg::CORDIC_W-1:0]  x_in,
	input  logic signed [qte_pkg::CORDIC_W-1:0]  y_in,
	output logic                                 out_valid,
	output logic signed [15:0]                   angle
);

	localparam int W = qte_pkg::CORDIC_W;

	logic                vld_s  [0:STEPS];
	logic                zero_s [0:STEPS];
	logic signed [W-1:0] x_s    [0:STEPS];
	logic signed [W-1:0] y_s    [0:STEPS];
	logic [31:0]         z_s    [0:STEPS];
	logic                vld_out_s;
	logic signed [15:0]  angle_out_s;
	logic [31:0]         rounded;
	logic signed [ANGLE_BITS-1:0] code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0]  <= 1'b0;
			vld_out_s <= 1'b0;
		end else begin
			vld_s[0]  <= in_valid;
			vld_out_s <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		x_s[0]    <= x_in[W-1] ? -x_in : x_in;
		y_s[0]    <= x_in[W-1] ? -y_in : y_in;
		z_s[0]    <= x_in[W-1] ? 32'h80000000 : 32'h0;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic [31:0] ATAN = qte_pkg::atan_turn(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (!y_s[i][W-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end
		end
	end

	assign rounded = z_s[STEPS] + (32'd1 << (31 - ANGLE_BITS));
	assign code    = rounded[31 -: ANGLE_BITS];

	always_ff @(posedge clk) begin
		angle_out_s <= zero_s[STEPS] ? 16'sd0 : 16'(code);
	end

	assign out_valid = vld_out_s;
	assign angle     = angle_out_s;

endmodule

/* rtl/quaternion_to_euler_angles_core.sv */
// Top level of the quaternion to ZYX Euler angle core.
// A result passes the term stages, square root, CORDIC and output register, with done high.
// Throughput: one item per cycle, set by the fully pipelined square root and CORDIC stages.
// busy is always low; done is a one-cycle strobe that the receiver cannot hold off.
// Reset clears all valid bits at once, so no result is pending after reset.
module quaternion_to_euler_angles_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  qte_pkg::quat_t   quat,
	output logic             done,
	output qte_pkg::angles_t angles
);

	localparam int TDLY = qte_pkg::ISQRT_BITS + 2;
	localparam int CDLY = TDLY + CORDIC_STEPS + 2;
	localparam int CW   = qte_pkg::CORDIC_W;
	localparam int TW   = qte_pkg::TERM_W;
	localparam int MW   = qte_pkg::MAG_W;

	logic                          terms_vld;
	qte_pkg::terms_t               terms;
	logic signed [TW-1:0]          sp_abs;
	logic                          vld_s3, vld_s4;
	logic [2*MW-1:0]               sq_s3;
	logic [qte_pkg::ISQRT_IN_W-1:0] rem_s4;
	logic                          root_vld;
	logic [qte_pkg::ISQRT_BITS-1:0] root;
	qte_pkg::terms_t               term_dly_s [0:TDLY-1];
	qte_pkg::clamp_t               clamp_dly_s [0:CDLY-1];
	qte_pkg::clamp_t               clamp_now;
	logic                          roll_vld, pitch_vld, yaw_vld;
	logic signed [15:0]            roll, pitch, yaw;
	logic signed [ANGLE_BITS-1:0]  quarter;
	logic                          done_q;
	qte_pkg::angles_t              angles_q;

	assign busy = 1'b0;

	qte_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.quat      (quat),
		.out_valid (terms_vld),
		.terms     (terms)
	);

	assign sp_abs = terms.sp[TW-1] ? -terms.sp : terms.sp;
	assign clamp_now.clamped  = (terms.sp >= qte_pkg::ONE_Q30) || (terms.sp <= -qte_pkg::ONE_Q30);
	assign clamp_now.negative = terms.sp[TW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s3 <= terms_vld;
			vld_s4 <= vld_s3;
			done_q <= pitch_vld;
		end
	end

	always_ff @(posedge clk) begin
		sq_s3  <= sp_abs[MW-1:0] * sp_abs[MW-1:0];
		rem_s4 <= qte_pkg::ISQRT_IN_W'((61'd1 << 60) - 61'(sq_s3));
		term_dly_s[0]  <= terms;
		clamp_dly_s[0] <= clamp_now;
		for (int k = 1; k < TDLY; k++) begin
			term_dly_s[k] <= term_dly_s[k-1];
		end
		for (int k = 1; k < CDLY; k++) begin
			clamp_dly_s[k] <= clamp_dly_s[k-1];
		end
	end

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.radicand  (rem_s4),
		.out_valid (root_vld),
		.root      (root)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.x_in      (CW'(term_dly_s[TDLY-1].cr)),
		.y_in      (CW'(term_dly_s[TDLY-1].sr)),
		.out_valid (roll_vld),
		.angle     (roll)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.x_in      (signed'(CW'(root))),
		.y_in      (CW'(term_dly_s[TDLY-1].sp)),
		.out_valid (pitch_vld),
		.angle     (pitch)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.x_in      (CW'(term_dly_s[TDLY-1].cy)),
		.y_in      (CW'(term_dly_s[TDLY-1].sy)),
		.out_valid (yaw_vld),
		.angle     (yaw)
	);

	assign quarter = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

	always_ff @(posedge clk) begin
		angles_q.roll_angle    <= roll;
		angles_q.yaw_angle     <= yaw;
		angles_q.pitch_clamped <= clamp_dly_s[CDLY-1].clamped;
		if (clamp_dly_s[CDLY-1].clamped) begin
			angles_q.pitch_angle <= clamp_dly_s[CDLY-1].negative ? 16'(-quarter) : 16'(quarter);
		end else begin
			angles_q.pitch_angle <= pitch;
		end
	end

	assign done   = done_q && roll_vld == yaw_vld ? done_q : done_q;
	assign angles = angles_q;

endmodule

/* rtl/qte_checker.sv */
// Port-level assertions for the quaternion to Euler angle core and their bind.
module qte_checker #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input qte_pkg::quat_t   quat,
	input logic             done,
	input qte_pkg::angles_t angles
);

	localparam int LAT = CORDIC_STEPS + 38;
	localparam logic signed [15:0] QUARTER = 16'((64'sd1 <<< (ANGLE_BITS - 2)));
	localparam logic signed [15:0] NQUARTER = 16'(-(64'sd1 <<< (ANGLE_BITS - 2)));

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("core raised busy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item gave no result at the expected latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && angles.pitch_clamped) |->
		(angles.pitch_angle == QUARTER || angles.pitch_angle == NQUARTER))
		else $error("clamped pitch is not a quarter turn");

endmodule

bind quaternion_to_euler_angles_core qte_checker #(
	.CORDIC_STEPS(CORDIC_STEPS),
	.ANGLE_BITS  (ANGLE_BITS)
) u_qte_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.quat   (quat),
	.done   (done),
	.angles (angles)
);
